@@ hw/rtl/swm_pkg.sv @@
package swm_pkg;

	// window length in samples
	localparam int unsigned WINDOW = 10;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W    = $clog2(WINDOW + 1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LATCH,
		ST_COUNT,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/swm_ram.sv @@
module swm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/sample_window_mode.sv @@
// sample_window_mode: windowed mode filter for 8-bit converter samples
//
// input channel s_*: one sample per transfer, s_tdata[7:0] = sample
// output channel m_*: one result per completed window,
//   m_tdata[7:0] = mode_value, the most frequent sample, smallest value on ties
//
// samples are written to a small window ram; the sample that fills the last
// slot starts the count. for each slot i the stored value is fetched and
// compared against every slot through one compare and one counter, then
// the result is handed to the output register. s_tready is low for that
// whole time; every other sample is accepted as soon as it is offered.
//
// the result sits in an output register; a stalled receiver does not block
// the samples of the next window, but a counted result waits in ST_DONE with
// s_tready low until the old one has gone.
// reset empties the window and drops any pending result; window contents
// are not cleared, as no slot is read before it is written.
module sample_window_mode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  swm_pkg::sample_t     s_tdata,    // [7:0] sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output swm_pkg::sample_t     m_tdata     // [7:0] mode_value
);

	import swm_pkg::*;

	state_t  state_q, state_d;
	idx_t    fill_q;
	idx_t    i_q;
	idx_t    k_q;
	cnt_t    n_q;
	cnt_t    best_cnt_q;
	sample_t best_val_q;
	sample_t v_q;
	logic    out_valid_q;
	sample_t out_q;

	logic    s_xfer;
	logic    ram_we;
	idx_t    ram_raddr;
	sample_t ram_rdata;
	logic    eq;
	cnt_t    n_sum;
	logic    better;
	logic    load_out;

	swm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (s_tdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_xfer = s_tvalid && s_tready;
	assign ram_we = s_xfer;

	// shared compare and counter
	assign eq     = (ram_rdata == v_q);
	assign n_sum  = n_q + CNT_W'(eq);
	assign better = (n_sum > best_cnt_q) || ((n_sum == best_cnt_q) && (v_q < best_val_q));

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_raddr = i_q;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (fill_q == LAST_IDX)) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				ram_raddr = i_q;
				state_d   = ST_LATCH;
			end
			ST_LATCH: begin
				ram_raddr = '0;
				state_d   = ST_COUNT;
			end
			ST_COUNT: begin
				ram_raddr = k_q + IDX_W'(1);
				if (k_q == LAST_IDX) begin
					state_d = (i_q == LAST_IDX) ? ST_DONE : ST_FETCH;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_xfer) begin
				fill_q <= (fill_q == LAST_IDX) ? '0 : fill_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers of the count sequence
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				i_q        <= '0;
				best_cnt_q <= '0;
				best_val_q <= '0;
			end
			ST_LATCH: begin
				v_q <= ram_rdata;
				k_q <= '0;
				n_q <= '0;
			end
			ST_COUNT: begin
				n_q <= n_sum;
				k_q <= k_q + IDX_W'(1);
				if (k_q == LAST_IDX) begin
					i_q <= i_q + IDX_W'(1);
					if (better) begin
						best_cnt_q <= n_sum;
						best_val_q <= v_q;
					end
				end
			end
			ST_DONE: begin
				if (load_out) begin
					out_q <= best_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
